FILE: hdl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// shared types and codes for the bitmap slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

    localparam int ADDR_W    = 48;
    localparam int OSZ_W     = 17;
    localparam int SCNT_W    = 7;
    localparam int IDX_OUT_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W    = 64;

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE      = 2'd1,
        OP_MARK_LIVE = 2'd2,
        OP_QUERY     = 2'd3
    } t_op;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NO_FREE = 2'd1;
    localparam logic [1:0] STS_OUTSIDE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd2;

    typedef struct packed {
        t_op               cmd;
        logic [ADDR_W-1:0] addr;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]    addr_out;
        logic [IDX_OUT_W-1:0] slot_index;
        logic [1:0]           status;
        logic                 is_live;
        logic                 in_chunk;
        logic                 any_free;
        logic                 all_free;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic prep;
        logic check;
        logic is_alloc;
        logic div_step;
        logic scan_step;
        logic mul;
        logic addr_calc;
        logic upd_set;
        logic upd_clr;
        logic upd_read;
        logic sum_init;
        logic sum_step;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_chunk;
        logic found;
        logic word_last;
        logic div_last;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hdl/bsa_dp.sv
// ----------------------------------------------------------------------------
// bsa_dp
// datapath: config registers, free map, chunk check, slot divider, scans
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_dp
    import bsa_pkg::*;
#(
    parameter int MAX_SLOTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic [ADDR_W-1:0]    i_addr,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output t_rsp                 o_rsp
);

    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int OFF_W     = SLOT_W + OSZ_W;
    localparam int EXT_W     = CNT_W + OSZ_W;
    localparam int MAP_WORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
    localparam int MAP_BITS  = MAP_WORDS * WORD_W;
    localparam int WD_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int STEP_W    = (SLOT_W > 1) ? $clog2(SLOT_W) : 1;
    localparam int BIT_W     = $clog2(WORD_W);

    // config
    logic [ADDR_W-1:0]   r_base_addr;
    logic [OSZ_W-1:0]    r_obj_size;
    logic [SCNT_W-1:0]   r_slot_count;

    logic [MAP_BITS-1:0] r_map;

    logic [ADDR_W-1:0]   r_addr;
    logic [OSZ_W-1:0]    r_osz;
    logic [CNT_W-1:0]    r_cnt;
    logic [EXT_W-1:0]    r_extent;
    logic [ADDR_W:0]     r_diff;
    logic [OFF_W-1:0]    r_rem;
    logic [STEP_W-1:0]   r_step;
    logic [SLOT_W-1:0]   r_idx;
    logic [WD_W-1:0]     r_wd;
    logic [OFF_W-1:0]    r_prod;
    logic [ADDR_W-1:0]   r_addr_out;
    logic [1:0]          r_status;
    logic                r_is_live;
    logic                r_inside;
    logic                r_any;
    logic                r_all;
    t_rsp                r_rsp;

    logic [OSZ_W-1:0]    osz_eff;
    logic [CNT_W-1:0]    cnt_eff;
    logic                inside_c;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   mask;
    logic [WORD_W-1:0]   avail;
    logic [BIT_W-1:0]    lowest;
    logic                found_c;
    logic                word_last;
    logic [OFF_W-1:0]    trial;
    logic                rem_ge;
    logic [MAP_BITS-1:0] sel;
    logic                any_n;
    logic                all_n;

    // zero object size acts as one, slot count saturates
    assign osz_eff = (r_obj_size == '0) ? OSZ_W'(1) : r_obj_size;
    assign cnt_eff = (32'(r_slot_count) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                         : CNT_W'(r_slot_count);

    // chunk end is not truncated, so the compare is on the full offset
    assign inside_c = !r_diff[ADDR_W] && (r_diff[ADDR_W-1:0] < ADDR_W'(r_extent));

    assign word = r_map[int'(r_wd) * WORD_W +: WORD_W];

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            mask[b] = (int'(r_wd) * WORD_W + b) < int'(r_cnt);
        end
    end

    assign avail = word & mask;

    // priority encoder, lowest set bit
    always_comb begin
        lowest = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (avail[b]) begin
                lowest = BIT_W'(b);
            end
        end
    end

    assign found_c   = |avail;
    assign word_last = (r_wd == WD_W'(MAP_WORDS - 1));

    // restoring divide, one quotient bit per step
    assign trial  = OFF_W'(r_osz) << r_step;
    assign rem_ge = (r_rem >= trial);

    always_comb begin
        for (int b = 0; b < MAP_BITS; b++) begin
            sel[b] = (b == int'(r_idx));
        end
    end

    assign any_n = r_any | found_c;
    assign all_n = r_all & (avail == mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_addr  <= '0;
            r_obj_size   <= OSZ_W'(1);
            r_slot_count <= SCNT_W'(64);
            r_map        <= '1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE_ADDR:  r_base_addr  <= i_cfg_data;
                    CFG_OBJ_SIZE:   r_obj_size   <= i_cfg_data[OSZ_W-1:0];
                    CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[SCNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.upd_set) begin
                r_map <= r_map | sel;
            end
            if (i_cmd.upd_clr) begin
                r_map <= r_map & ~sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_addr <= i_addr;
        end
        if (i_cmd.prep) begin
            r_osz    <= osz_eff;
            r_cnt    <= cnt_eff;
            r_extent <= EXT_W'(cnt_eff) * EXT_W'(osz_eff);
            r_diff   <= {1'b0, r_addr} - {1'b0, r_base_addr};
        end
        if (i_cmd.check) begin
            r_rem      <= r_diff[OFF_W-1:0];
            r_step     <= STEP_W'(SLOT_W - 1);
            r_idx      <= '0;
            r_addr_out <= '0;
            r_is_live  <= 1'b0;
            r_inside   <= inside_c;
            r_status   <= (!inside_c && !i_cmd.is_alloc) ? STS_OUTSIDE : STS_OK;
        end
        if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem         <= r_rem - trial;
                r_idx[r_step] <= 1'b1;
            end
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.scan_step) begin
            if (found_c) begin
                r_idx <= SLOT_W'(int'(r_wd) * WORD_W + int'(lowest));
            end else if (word_last) begin
                r_status <= STS_NO_FREE;
            end
        end
        // word pointer shared by the allocate scan and the summary pass
        if (i_cmd.check || i_cmd.sum_init) begin
            r_wd <= '0;
        end else if ((i_cmd.scan_step && !found_c) || i_cmd.sum_step) begin
            if (!word_last) begin
                r_wd <= r_wd + WD_W'(1);
            end
        end
        if (i_cmd.mul) begin
            r_prod <= OFF_W'(r_idx) * OFF_W'(r_osz);
        end
        if (i_cmd.addr_calc) begin
            r_addr_out <= r_base_addr + ADDR_W'(r_prod);
        end
        if (i_cmd.upd_read) begin
            r_is_live <= ~|(r_map & sel);
        end
        if (i_cmd.sum_init) begin
            r_any <= 1'b0;
            r_all <= 1'b1;
        end else if (i_cmd.sum_step) begin
            r_any <= any_n;
            r_all <= all_n;
        end
        if (i_cmd.load_out) begin
            r_rsp.addr_out   <= r_addr_out;
            r_rsp.slot_index <= IDX_OUT_W'(r_idx);
            r_rsp.status     <= r_status;
            r_rsp.is_live    <= r_is_live;
            r_rsp.in_chunk   <= r_inside;
            r_rsp.any_free   <= any_n;
            r_rsp.all_free   <= all_n;
        end
    end

    assign o_stat.in_chunk  = inside_c;
    assign o_stat.found     = found_c;
    assign o_stat.word_last = word_last;
    assign o_stat.div_last  = (r_step == '0);
    assign o_rsp            = r_rsp;

endmodule

`default_nettype wire

FILE: hdl/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// bsa_ctrl
// sequencer for one request: check, divide or scan, update, summary
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl
    import bsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_op      i_op,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_strobe
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_PREP   = 9'b000000010,
        ST_CHECK  = 9'b000000100,
        ST_DIV    = 9'b000001000,
        ST_SCAN   = 9'b000010000,
        ST_MUL    = 9'b000100000,
        ST_ADDR   = 9'b001000000,
        ST_UPDATE = 9'b010000000,
        ST_SUM    = 9'b100000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_op     r_op;
    logic    r_strobe;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    cmd.load_req = 1'b1;
                    n_state      = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
                n_state  = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check    = 1'b1;
                cmd.is_alloc = (r_op == OP_ALLOC);
                if (r_op == OP_ALLOC) begin
                    n_state = ST_SCAN;
                end else if (i_stat.in_chunk) begin
                    n_state = ST_DIV;
                end else begin
                    cmd.sum_init = 1'b1;
                    n_state      = ST_SUM;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_stat.found) begin
                    n_state = ST_MUL;
                end else if (i_stat.word_last) begin
                    cmd.sum_init = 1'b1;
                    n_state      = ST_SUM;
                end
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
                n_state = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr_calc = 1'b1;
                n_state       = ST_UPDATE;
            end
            ST_UPDATE: begin
                unique case (r_op) inside
                    OP_ALLOC, OP_MARK_LIVE: cmd.upd_clr = 1'b1;
                    OP_FREE:                cmd.upd_set = 1'b1;
                    OP_QUERY:               cmd.upd_read = 1'b1;
                endcase
                cmd.sum_init = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (i_stat.word_last) begin
                    cmd.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= cmd.load_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load_req) begin
            r_op <= i_op;
        end
    end

    assign o_cmd    = cmd;
    assign o_busy   = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

FILE: hdl/bitmap_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// slot pool allocator over one memory chunk, one free bit per slot
// ----------------------------------------------------------------------------
// usage
//   request: drive i_req (cmd, addr) and raise start; the transfer happens
//   at a clock edge with start high and busy low. busy stays high while the
//   request is worked on.
//   result: o_rsp is valid for exactly one cycle with o_strobe high; the
//   receiver cannot stall, so it must take it then. busy drops in the same
//   cycle, so a new request may be started while the result is shown.
//   config: i_cfg_valid with i_cfg_index / i_cfg_data; o_cfg_ready is always
//   high. index 0 base address, 1 object size, 2 slot count. write only
//   while busy is low and no result is pending.
// sequence
//   allocate: prep, check, scan map words to the first free slot, multiply,
//   address, update, then a summary pass over all map words
//   free / mark live / query inside: prep, check, divide, update, summary
//   outside the chunk: prep, check, summary; nothing free: full scan, summary
//   divider: one quotient bit per cycle; one request in flight at a time
// reset
//   synchronous, active low: map all free, base 0, object size 1,
//   slot count 64, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator_top
    import bsa_pkg::*;
#(
    parameter int MAX_SLOTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    // result channel
    output logic                 o_strobe,
    output t_rsp                 o_rsp,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // config is always taken; the register file sits in the datapath
    assign o_cfg_ready = 1'b1;

    bsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_req.cmd),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    bsa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_addr      (i_req.addr),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

FILE: hdl/bsa_checker.sv
// ----------------------------------------------------------------------------
// bsa_checker
// port level checks on the request and result transfers
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_checker
    import bsa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_rsp o_rsp
);

    // a request transfer makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not set after request transfer");

    // the result closes the request
    a_fell_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result");

    a_idle_at_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while still busy");

    // outside address touches nothing and reports nothing
    a_outside_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status == STS_OUTSIDE) |->
            (!o_rsp.in_chunk && o_rsp.slot_index == '0 && o_rsp.addr_out == '0
             && !o_rsp.is_live))
        else $error("outside result carries slot data");

    // failed allocate means the map had nothing free
    a_no_free_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status == STS_NO_FREE) |->
            (!o_rsp.any_free && o_rsp.addr_out == '0 && o_rsp.slot_index == '0))
        else $error("no free status with a free slot");

endmodule

bind bitmap_slot_allocator_top bsa_checker u_bsa_checker (.*);

`default_nettype wire

FILE: verif/bitmap_slot_allocator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top_tb
// self-checking bench for the slot pool allocator: a directed table at the
// chunk edges, then random allocate / free / mark-live / query traffic over
// several chunk settings, each result checked against its row or a bench model
// ----------------------------------------------------------------------------

module bitmap_slot_allocator_top_tb;

    import bsa_pkg::*;

    localparam int MAX_SLOTS   = 64;
    localparam int PHASES      = 8;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_GAP     = 20;
    localparam int DIR_ROWS    = 28;

    // index that no register answers to, written once to show it is ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // directed table: one row is either a request transfer or a register write
    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_idx;  // write rows only
        t_op                  cmd;      // request rows only
        logic [ADDR_W-1:0]    value;    // request address or register data
        logic                 typed;    // expectation spelled out in rsp
        t_rsp                 rsp;
    } t_dir_row;

    localparam t_rsp NO_RSP = '0;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_req              i_req       = '0;
    logic              o_strobe;
    t_rsp              o_rsp;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ADDR_W-1:0] i_cfg_data  = '0;

    // model copy of the block: register values and the free map (1 = free)
    logic [ADDR_W-1:0] cfg_base  = '0;
    logic [OSZ_W-1:0]  cfg_osz   = 17'd1;
    logic [SCNT_W-1:0] cfg_slots = 7'd64;
    logic [63:0]       pool_map  = '1;

    // results still owed by the block, oldest first
    t_rsp        rsp_due_q[$];
    t_rsp        mon_want;
    int unsigned sender_idle_pct = 33;
    int unsigned mismatches      = 0;
    int unsigned results_checked = 0;
    int unsigned reqs_sent       = 0;
    int unsigned cfg_writes      = 0;
    int unsigned cycle_cnt       = 0;

    // directed rows: reset state first, then shrink the pool to one slot,
    // zero slot size at the top of the address space, no slots at all,
    // and an oversized count with allocations that wrap past 2^48
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_REQ, CFG_BASE_ADDR, OP_QUERY, 48'h0000_0000_0000, 1'b1,
          '{48'h0, 6'd0, STS_OK, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_ALLOC, 48'hFFFF_FFFF_FFFF, 1'b1,
          '{48'h0, 6'd0, STS_OK, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_ALLOC, 48'h0000_0000_0000, 1'b1,
          '{48'h1, 6'd1, STS_OK, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_QUERY, 48'h0000_0000_0001, 1'b1,
          '{48'h0, 6'd1, STS_OK, 1'b1, 1'b1, 1'b1, 1'b0}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_FREE, 48'h0000_0000_0040, 1'b1,
          '{48'h0, 6'd0, STS_OUTSIDE, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_MARK_LIVE, 48'h0000_0000_003F, 1'b1,
          '{48'h0, 6'd63, STS_OK, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_QUERY, 48'hFFFF_FFFF_FFFF, 1'b1,
          '{48'h0, 6'd0, STS_OUTSIDE, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_FREE, 48'h0000_0000_0000, 1'b1,
          '{48'h0, 6'd0, STS_OK, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_FREE, 48'h0000_0000_0001, 1'b1,
          '{48'h0, 6'd1, STS_OK, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_FREE, 48'h0000_0000_003F, 1'b1,
          '{48'h0, 6'd63, STS_OK, 1'b0, 1'b1, 1'b1, 1'b1}},
        // one-slot pool: first allocate takes it, second finds nothing
        '{ROW_CFG, CFG_SLOT_COUNT, OP_ALLOC, 48'h0000_0000_0001, 1'b0, NO_RSP},
        '{ROW_REQ, CFG_BASE_ADDR, OP_ALLOC, 48'h0000_0000_0000, 1'b1,
          '{48'h0, 6'd0, STS_OK, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_ALLOC, 48'h0000_0000_0000, 1'b1,
          '{48'h0, 6'd0, STS_NO_FREE, 1'b0, 1'b1, 1'b0, 1'b0}},
        // zero slot size acts as one byte; chunk is the last address only
        '{ROW_CFG, CFG_OBJ_SIZE, OP_ALLOC, 48'h0000_0000_0000, 1'b0, NO_RSP},
        '{ROW_CFG, CFG_BASE_ADDR, OP_ALLOC, 48'hFFFF_FFFF_FFFF, 1'b0, NO_RSP},
        '{ROW_REQ, CFG_BASE_ADDR, OP_QUERY, 48'hFFFF_FFFF_FFFF, 1'b1,
          '{48'h0, 6'd0, STS_OK, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_FREE, 48'hFFFF_FFFF_FFFE, 1'b1,
          '{48'h0, 6'd0, STS_OUTSIDE, 1'b0, 1'b0, 1'b0, 1'b0}},
        // no slots: nothing allocatable, nothing inside, pool counts as empty
        '{ROW_CFG, CFG_SLOT_COUNT, OP_ALLOC, 48'h0000_0000_0000, 1'b0, NO_RSP},
        '{ROW_REQ, CFG_BASE_ADDR, OP_ALLOC, 48'hFFFF_FFFF_FFFF, 1'b1,
          '{48'h0, 6'd0, STS_NO_FREE, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{ROW_REQ, CFG_BASE_ADDR, OP_QUERY, 48'hFFFF_FFFF_FFFF, 1'b1,
          '{48'h0, 6'd0, STS_OUTSIDE, 1'b0, 1'b0, 1'b0, 1'b1}},
        // count above the pool size saturates; 64 KiB slots near the top
        '{ROW_CFG, CFG_SLOT_COUNT, OP_ALLOC, 48'h0000_0000_007F, 1'b0, NO_RSP},
        '{ROW_CFG, CFG_OBJ_SIZE, OP_ALLOC, 48'h0000_0001_0000, 1'b0, NO_RSP},
        '{ROW_CFG, CFG_BASE_ADDR, OP_ALLOC, 48'hFFFF_FFFF_0000, 1'b0, NO_RSP},
        '{ROW_REQ, CFG_BASE_ADDR, OP_ALLOC, 48'h0000_0000_0000, 1'b0, NO_RSP},
        '{ROW_REQ, CFG_BASE_ADDR, OP_QUERY, 48'hFFFF_FFFF_FFFF, 1'b0, NO_RSP},
        '{ROW_REQ, CFG_BASE_ADDR, OP_FREE, 48'hFFFF_FFFF_0000, 1'b0, NO_RSP},
        '{ROW_REQ, CFG_BASE_ADDR, OP_MARK_LIVE, 48'h0000_0000_0000, 1'b0, NO_RSP},
        '{ROW_REQ, CFG_BASE_ADDR, OP_ALLOC, 48'h5555_5555_5555, 1'b0, NO_RSP}
    };

    bitmap_slot_allocator_top #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // slot size as the block uses it: zero counts as one byte
    function automatic logic [63:0] slot_bytes();
        return (cfg_osz == '0) ? 64'd1 : 64'(cfg_osz);
    endfunction

    // slot count as the block uses it: capped at the pool size
    function automatic logic [63:0] slots_used();
        return (cfg_slots > SCNT_W'(MAX_SLOTS)) ? 64'(MAX_SLOTS) : 64'(cfg_slots);
    endfunction

    // works out the result of one request and updates the model free map
    function automatic t_rsp alloc_predict(input t_req req);
        logic [63:0] osz;
        logic [63:0] cnt;
        logic [63:0] extent;
        logic [63:0] offs;
        logic [63:0] mask;
        logic [63:0] avail;
        logic [63:0] slot;
        logic        in_range;
        t_rsp        rsp;
        osz    = slot_bytes();
        cnt    = slots_used();
        extent = cnt * osz;
        // 64-bit math so the chunk end never wraps at 2^48
        offs     = 64'(req.addr) - 64'(cfg_base);
        in_range = (req.addr >= cfg_base) && (offs < extent);
        mask     = (cnt >= 64'(MAX_SLOTS)) ? '1 : ((64'd1 << cnt) - 64'd1);
        rsp          = '0;
        rsp.in_chunk = in_range;
        if (req.cmd == OP_ALLOC) begin
            avail = pool_map & mask;
            if (avail == '0) begin
                rsp.status = STS_NO_FREE;
            end else begin
                slot = '0;
                for (int b = MAX_SLOTS - 1; b >= 0; b--) begin
                    if (avail[b]) slot = 64'(b);
                end
                pool_map[slot[5:0]] = 1'b0;
                rsp.addr_out   = ADDR_W'(64'(cfg_base) + slot * osz);
                rsp.slot_index = slot[5:0];
            end
        end else if (!in_range) begin
            rsp.status = STS_OUTSIDE;
        end else begin
            // misaligned addresses truncate to the slot they start in
            slot           = offs / osz;
            rsp.slot_index = slot[5:0];
            case (req.cmd)
                OP_FREE:      pool_map[slot[5:0]] = 1'b1;
                OP_MARK_LIVE: pool_map[slot[5:0]] = 1'b0;
                default:      rsp.is_live = !pool_map[slot[5:0]];
            endcase
        end
        // bits above the slot count stay as they are but do not count
        rsp.any_free = |(pool_map & mask);
        rsp.all_free = ((pool_map & mask) == mask);
        return rsp;
    endfunction

    // mostly slot addresses inside the chunk, some off by a few bytes,
    // some right at the chunk edges and the rest anywhere in the space
    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [63:0] osz;
        logic [63:0] cnt;
        logic [63:0] slot;
        logic [63:0] offs;
        int unsigned sel;
        osz = slot_bytes();
        cnt = slots_used();
        sel = $urandom_range(99);
        if (sel < 70 && cnt != '0) begin
            slot = 64'($urandom_range(32'(cnt - 64'd1)));
            offs = ($urandom_range(3) == 0) ? 64'($urandom) % osz : 64'd0;
            return ADDR_W'(64'(cfg_base) + slot * osz + offs);
        end else if (sel < 85) begin
            case ($urandom_range(3))
                0:       return cfg_base - ADDR_W'(1);
                1:       return ADDR_W'(64'(cfg_base) + cnt * osz);
                2:       return ADDR_W'(64'(cfg_base) + cnt * osz - 64'd1);
                default: return cfg_base;
            endcase
        end
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // register write, only once the block is idle and owes nothing
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [ADDR_W-1:0] data);
        do @(posedge i_clk); while (busy || rsp_due_q.size() != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BASE_ADDR:  cfg_base  = data;
            CFG_OBJ_SIZE:   cfg_osz   = data[OSZ_W-1:0];
            CFG_SLOT_COUNT: cfg_slots = data[SCNT_W-1:0];
            default:        ;
        endcase
        cfg_writes++;
    endtask

    // one request transfer; start stays high afterwards unless the next
    // call idles first, so back-to-back requests never toggle it
    task automatic send_req(input t_req req, input logic typed, input t_rsp rsp);
        int   gap;
        t_rsp predicted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        // busy here is the value before the edge, so this is the transfer
        do @(posedge i_clk); while (busy);
        predicted = alloc_predict(req);
        rsp_due_q.push_back(typed ? rsp : predicted);
        reqs_sent++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // result side: each strobe is a transfer that cannot be held off
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (rsp_due_q.size() == 0) begin
                $error("result with no request outstanding: 0x%0h", o_rsp);
                mismatches++;
            end else begin
                mon_want = rsp_due_q.pop_front();
                check_field("addr_out",   mon_want.addr_out,   o_rsp.addr_out);
                check_field("slot_index", mon_want.slot_index, o_rsp.slot_index);
                check_field("status",     mon_want.status,     o_rsp.status);
                check_field("is_live",    mon_want.is_live,    o_rsp.is_live);
                check_field("in_chunk",   mon_want.in_chunk,   o_rsp.in_chunk);
                check_field("any_free",   mon_want.any_free,   o_rsp.any_free);
                check_field("all_free",   mon_want.all_free,   o_rsp.all_free);
                results_checked++;
            end
        end
    end

    // watchdog against a hang anywhere in the run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed",
                     cycle_cnt, rsp_due_q.size());
            $display("** bitmap_slot_allocator_top: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        t_req              req;
        logic [ADDR_W-1:0] base;
        logic [OSZ_W-1:0]  osz;
        logic [SCNT_W-1:0] scnt;
        int unsigned       alloc_pct;
        int unsigned       n_items;
        int unsigned       drain;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, starting from the reset settings
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                start <= 1'b0;
                cfg_write(dir_rows[r].reg_idx, dir_rows[r].value);
            end else begin
                req.cmd  = dir_rows[r].cmd;
                req.addr = dir_rows[r].value;
                send_req(req, dir_rows[r].typed, dir_rows[r].rsp);
            end
        end
        start <= 1'b0;

        // random phases; the free map carries over, so bits hidden by a
        // smaller count come back into view when a later phase grows it
        alloc_pct = 45;
        for (int p = 0; p < PHASES; p++) begin
            sender_idle_pct = (p < 3) ? 33 : (p < 6) ? 76 : 0;
            base = ADDR_W'({$urandom, $urandom});
            osz  = OSZ_W'($urandom_range(1, 65536));
            scnt = SCNT_W'($urandom_range(1, 64));
            case (p)
                0: begin
                    base = '0;
                    osz  = 17'd1;
                    scnt = 7'd64;
                end
                // chunk runs past 2^48, so allocated addresses wrap
                2: begin
                    base = 48'hFFFF_FFFF_FC18;
                    osz  = 17'd100;
                    scnt = 7'd64;
                end
                3: begin
                    osz  = '0;
                    scnt = SCNT_W'($urandom_range(1, 8));
                end
                // 64 KiB slots near the top: only the low slots reachable
                4: begin
                    base = 48'hFFFF_FFF0_0000;
                    osz  = 17'h10000;
                    scnt = 7'd127;
                end
                5: begin
                    osz  = 17'd7;
                    scnt = '0;
                end
                6: osz = '1;
                7: begin
                    osz  = OSZ_W'($urandom_range(1, 300));
                    scnt = 7'd64;
                end
                default: ;
            endcase
            // bits above each register's width are junk and must be ignored
            cfg_write(CFG_BASE_ADDR, base);
            cfg_write(CFG_OBJ_SIZE, {31'($urandom), osz});
            cfg_write(CFG_SLOT_COUNT, {41'({$urandom, $urandom}), scnt});
            if (p == 0) cfg_write(CFG_SPARE, '1);

            n_items = (scnt == '0) ? 50 : 270;
            for (int n = 0; n < n_items; n++) begin
                // runs of allocation-heavy traffic fill the pool,
                // free-heavy runs drain it
                if (n % 50 == 0) begin
                    case ($urandom_range(2))
                        0:       alloc_pct = 15;
                        1:       alloc_pct = 45;
                        default: alloc_pct = 80;
                    endcase
                end
                if ($urandom_range(99) < alloc_pct) begin
                    req.cmd = OP_ALLOC;
                end else begin
                    case ($urandom_range(2))
                        0:       req.cmd = OP_FREE;
                        1:       req.cmd = OP_MARK_LIVE;
                        default: req.cmd = OP_QUERY;
                    endcase
                end
                req.addr = pick_addr();
                send_req(req, 1'b0, NO_RSP);
            end
            start <= 1'b0;
        end

        // drain, then watch the tail for stray strobes
        drain = 0;
        while (rsp_due_q.size() != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (rsp_due_q.size() != 0) begin
            $error("%0d results never arrived", rsp_due_q.size());
            mismatches++;
        end

        $display("sent %0d requests over %0d chunk settings with %0d register writes",
                 reqs_sent, PHASES + 4, cfg_writes);
        $display("compared %0d results field by field, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("** bitmap_slot_allocator_top: PASSED **");
        end else begin
            $display("** bitmap_slot_allocator_top: FAILED **");
        end
        $finish;
    end

endmodule
